[design/abrr_pkg.sv]
// Shared constants, types and color helper for the attribute/bitmap raster renderer.
package abrr_pkg;

    localparam int BORDER_WIDTH = 32;
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 256;
    localparam int PIC_W        = 256;
    localparam int PIC_H        = 192;

    localparam int BMP_DEPTH  = 6144;
    localparam int ATTR_DEPTH = 768;

    localparam logic [12:0] ATTR_BASE  = 13'h1800;
    localparam logic [12:0] STORE_SIZE = 13'd6912;

    localparam logic [9:0] WIN_X_LO = 10'(BORDER_WIDTH);
    localparam logic [9:0] WIN_X_HI = 10'(BORDER_WIDTH + PIC_W);
    localparam logic [9:0] WIN_Y_LO = 10'(BORDER_WIDTH);
    localparam logic [9:0] WIN_Y_HI = 10'(BORDER_WIDTH + PIC_H);

    localparam logic [8:0] X_LAST = 9'(FRAME_WIDTH - 1);
    localparam logic [8:0] Y_LAST = 9'(FRAME_HEIGHT - 1);

    localparam logic [7:0] LEVEL_ON = 8'hee;
    localparam logic [7:0] ALPHA    = 8'hff;

    typedef struct packed {
        logic        en;
        logic [12:0] addr;
        logic [7:0]  data;
    } t_wr_req;

    typedef struct packed {
        logic        en;
        logic [12:0] bmp_addr;
        logic [9:0]  attr_addr;
    } t_rd_req;

    function automatic logic [31:0] grb_to_argb(input logic [2:0] grb);
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] b;
        g = grb[2] ? LEVEL_ON : 8'h00;
        r = grb[1] ? LEVEL_ON : 8'h00;
        b = grb[0] ? LEVEL_ON : 8'h00;
        return {ALPHA, b, g, r};
    endfunction

endpackage

[design/abrr_screen_mem.sv]
// Screen store: bitmap and attribute memories with one write port and registered reads.
module abrr_screen_mem (
    input  logic             i_clk,
    input  abrr_pkg::t_wr_req i_wr,
    input  abrr_pkg::t_rd_req i_rd,
    output logic [7:0]       o_bmp_data,
    output logic [7:0]       o_attr_data
);

    logic [7:0] r_bmp  [abrr_pkg::BMP_DEPTH];
    logic [7:0] r_attr [abrr_pkg::ATTR_DEPTH];

    logic [7:0] r_bmp_data;
    logic [7:0] r_attr_data;

    logic       bmp_we;
    logic       attr_we;
    logic [9:0] attr_waddr;

    assign bmp_we     = i_wr.en && (i_wr.addr < abrr_pkg::ATTR_BASE);
    assign attr_we    = i_wr.en && (i_wr.addr >= abrr_pkg::ATTR_BASE)
                        && (i_wr.addr < abrr_pkg::STORE_SIZE);
    assign attr_waddr = 10'(i_wr.addr - abrr_pkg::ATTR_BASE);

    always_ff @(posedge i_clk) begin
        if (bmp_we) begin
            r_bmp[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_bmp_data <= r_bmp[i_rd.bmp_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            r_attr[attr_waddr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_attr_data <= r_attr[i_rd.attr_addr];
        end
    end

    assign o_bmp_data  = r_bmp_data;
    assign o_attr_data = r_attr_data;

endmodule

[design/attribute_bitmap_raster_renderer.sv]
// Top level of the attribute/bitmap raster renderer.
// A tick transaction reads screen memory at its accepting edge while its raster fields
// are captured in stage 1; its pixel is then loaded into the output register and o_out_valid
// rises once the output register is free; writes give no result.
// Throughput: one transaction per cycle while the output is not stalled, set by the memory read port.
// Reset (synchronous, active low) clears the raster position, border color and
// pipeline valids; screen memory contents are undefined until written.
module attribute_bitmap_raster_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [12:0] i_mem_addr,
    input  logic [7:0]  i_mem_data,
    input  logic        i_flash_phase,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pixel_argb,
    output logic [8:0]  o_pixel_x,
    output logic [8:0]  o_pixel_y,
    output logic        o_frame_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata
);

    logic [2:0] r_border;
    logic [8:0] r_col;
    logic [8:0] r_line;
    logic [8:0] n_col;
    logic [8:0] n_line;

    logic       r_s1_valid;
    logic       r_s1_pic;
    logic [2:0] r_s1_bit;
    logic       r_s1_flash;
    logic [8:0] r_s1_x;
    logic [8:0] r_s1_y;
    logic       r_s1_last;

    logic        r_out_valid;
    logic [31:0] r_argb;
    logic [8:0]  r_x;
    logic [8:0]  r_y;
    logic        r_last;

    logic        out_free;
    logic        s1_free;
    logic        accept;
    logic        tick;
    logic        in_pic;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [7:0]  bmp_data;
    logic [7:0]  attr_data;
    logic        sel_ink;
    logic [2:0]  pix_grb;
    logic [31:0] pix_argb;

    abrr_pkg::t_wr_req wr_req;
    abrr_pkg::t_rd_req rd_req;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_ready = s1_free;
    assign accept     = i_in_valid && s1_free;
    assign tick       = accept && i_action;

    assign in_pic = ({1'b0, r_col} >= abrr_pkg::WIN_X_LO) && ({1'b0, r_col} < abrr_pkg::WIN_X_HI)
                 && ({1'b0, r_line} >= abrr_pkg::WIN_Y_LO) && ({1'b0, r_line} < abrr_pkg::WIN_Y_HI);
    assign px = 8'(r_col - 9'(abrr_pkg::BORDER_WIDTH));
    assign py = 8'(r_line - 9'(abrr_pkg::BORDER_WIDTH));

    assign wr_req.en   = accept && !i_action;
    assign wr_req.addr = i_mem_addr;
    assign wr_req.data = i_mem_data;

    assign rd_req.en        = tick && in_pic;
    assign rd_req.bmp_addr  = {py[7:6], py[2:0], py[5:3], px[7:3]};
    assign rd_req.attr_addr = {py[7:3], px[7:3]};

    abrr_screen_mem u_mem (
        .i_clk       (i_clk),
        .i_wr        (wr_req),
        .i_rd        (rd_req),
        .o_bmp_data  (bmp_data),
        .o_attr_data (attr_data)
    );

    always_comb begin
        n_col  = r_col + 9'd1;
        n_line = r_line;
        if (r_col == abrr_pkg::X_LAST) begin
            n_col = '0;
            if (r_line == abrr_pkg::Y_LAST) begin
                n_line = '0;
            end else begin
                n_line = r_line + 9'd1;
            end
        end
    end

    // swap ink and paper on flashing cells during the flash phase
    assign sel_ink  = bmp_data[3'd7 - r_s1_bit] ^ (attr_data[7] && r_s1_flash);
    assign pix_grb  = !r_s1_pic ? r_border : (sel_ink ? attr_data[2:0] : attr_data[5:3]);
    assign pix_argb = abrr_pkg::grb_to_argb(pix_grb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border    <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_border <= i_cfg_wdata;
            end
            if (tick) begin
                r_col  <= n_col;
                r_line <= n_line;
            end
            if (s1_free) begin
                r_s1_valid <= tick;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_s1_pic   <= in_pic;
            r_s1_bit   <= px[2:0];
            r_s1_flash <= i_flash_phase;
            r_s1_x     <= r_col;
            r_s1_y     <= r_line;
            r_s1_last  <= (r_col == abrr_pkg::X_LAST) && (r_line == abrr_pkg::Y_LAST);
        end
        if (out_free && r_s1_valid) begin
            r_argb <= pix_argb;
            r_x    <= r_s1_x;
            r_y    <= r_s1_y;
            r_last <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_argb = r_argb;
    assign o_pixel_x    = r_x;
    assign o_pixel_y    = r_y;
    assign o_frame_last = r_last;

endmodule

[verif/tb_attribute_bitmap_raster_renderer.sv]
// Self-checking testbench for the attribute/bitmap raster renderer: store fill and raster sweep.
module tb_attribute_bitmap_raster_renderer;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int FILL_WRITES  = 120;
    localparam int SWEEP_ITEMS  = 115;
    localparam int MAX_REPORTS  = 10;
    localparam int STORE_BYTES  = abrr_pkg::BMP_DEPTH + abrr_pkg::ATTR_DEPTH;

    localparam logic [3:0][2:0] DIRECTED_BORDER = {3'd4, 3'd2, 3'd1, 3'd7};
    localparam logic [3:0][2:0] SWEEP_BORDER    = {3'd7, 3'd2, 3'd5, 3'd0};

    typedef struct packed {
        logic [31:0] argb;
        logic [8:0]  x;
        logic [8:0]  y;
        logic        last;
    } t_pixel;

    class pixel_scoreboard;
        logic [7:0] screen [0:STORE_BYTES-1];
        logic [8:0] column;
        logic [8:0] line;
        logic [2:0] border;
        t_pixel     pending_pixels[$];
        int         errors;

        function new();
            column = '0;
            line   = '0;
            border = '0;
            errors = 0;
        endfunction

        function logic in_picture();
            return column >= abrr_pkg::WIN_X_LO && column < abrr_pkg::WIN_X_HI &&
                   line >= abrr_pkg::WIN_Y_LO && line < abrr_pkg::WIN_Y_HI;
        endfunction

        function logic [12:0] cell_offset(logic want_attr);
            logic [7:0] px;
            logic [7:0] py;
            px = 8'(column - 9'(abrr_pkg::BORDER_WIDTH));
            py = 8'(line - 9'(abrr_pkg::BORDER_WIDTH));
            if (want_attr) begin
                return abrr_pkg::ATTR_BASE + 13'({py[7:3], px[7:3]});
            end
            return {py[7:6], py[2:0], py[5:3], px[7:3]};
        endfunction

        function logic [31:0] level_color(logic [2:0] grb);
            return {abrr_pkg::ALPHA, grb[0] ? abrr_pkg::LEVEL_ON : 8'h00,
                    grb[2] ? abrr_pkg::LEVEL_ON : 8'h00,
                    grb[1] ? abrr_pkg::LEVEL_ON : 8'h00};
        endfunction

        function logic [31:0] render_pixel(logic flash);
            logic [7:0] attr;
            logic [7:0] bits;
            logic [2:0] ink;
            logic [2:0] paper;
            logic [2:0] swap;
            logic [2:0] bit_sel;
            if (!in_picture()) begin
                return level_color(border);
            end
            attr    = screen[cell_offset(1'b1)];
            bits    = screen[cell_offset(1'b0)];
            bit_sel = 3'd7 - 3'(column - 9'(abrr_pkg::BORDER_WIDTH));
            ink     = attr[2:0];
            paper   = attr[5:3];
            if (attr[7] && flash) begin
                swap  = ink;
                ink   = paper;
                paper = swap;
            end
            return level_color(bits[bit_sel] ? ink : paper);
        endfunction

        function void set_border(logic [2:0] value);
            border = value;
        endfunction

        function void note_transaction(logic act, logic [12:0] addr, logic [7:0] data,
                                       logic flash);
            t_pixel px;
            if (act == ACT_WRITE) begin
                if (addr < abrr_pkg::STORE_SIZE) begin
                    screen[addr] = data;
                end
                return;
            end
            px.argb = render_pixel(flash);
            px.x    = column;
            px.y    = line;
            px.last = (column == abrr_pkg::X_LAST) && (line == abrr_pkg::Y_LAST);
            pending_pixels.push_back(px);
            if (column == abrr_pkg::X_LAST) begin
                column = '0;
                line   = (line == abrr_pkg::Y_LAST) ? 9'd0 : line + 9'd1;
            end else begin
                column = column + 9'd1;
            end
        endfunction

        function void check_pixel(logic [31:0] argb, logic [8:0] x, logic [8:0] y, logic last);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected pixel: argb=%h x=%0d y=%0d last=%b", argb, x, y, last);
                end
                return;
            end
            want = pending_pixels.pop_front();
            if (argb !== want.argb || x !== want.x || y !== want.y || last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("pixel mismatch: expected argb=%h x=%0d y=%0d last=%b",
                             want.argb, want.x, want.y, want.last);
                    $display("                got      argb=%h x=%0d y=%0d last=%b",
                             argb, x, y, last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [12:0] i_mem_addr;
    logic [7:0]  i_mem_data;
    logic        i_flash_phase;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_pixel_argb;
    logic [8:0]  o_pixel_x;
    logic [8:0]  o_pixel_y;
    logic        o_frame_last;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;

    pixel_scoreboard pixels;
    int idle_pct;
    int stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;

    attribute_bitmap_raster_renderer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_mem_addr    (i_mem_addr),
        .i_mem_data    (i_mem_data),
        .i_flash_phase (i_flash_phase),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_argb  (o_pixel_argb),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixels.check_pixel(o_pixel_argb, o_pixel_x, o_pixel_y, o_frame_last);
        end
    end

    task automatic send_item(input logic act, input logic [12:0] addr, input logic [7:0] data,
                             input logic flash);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_mem_addr    <= addr;
        i_mem_data    <= data;
        i_flash_phase <= flash;
        do @(posedge i_clk); while (!o_in_ready);
        pixels.note_transaction(act, addr, data, flash);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pixels.pending_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_border(input logic [2:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pixels.set_border(value);
    endtask

    initial begin
        #25_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int pick;
        logic [12:0] addr;
        pixels        = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_WRITE;
        i_mem_addr    = '0;
        i_mem_data    = '0;
        i_flash_phase = 1'b0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset border and origin, ignored fields at their extremes, writes past the store
        send_item(ACT_TICK, 13'h1fff, 8'hff, 1'b1);
        send_item(ACT_TICK, 13'h0000, 8'h00, 1'b0);
        send_item(ACT_WRITE, abrr_pkg::STORE_SIZE, 8'hff, 1'b1);
        send_item(ACT_WRITE, 13'h1fff, 8'h00, 1'b0);
        for (int i = 0; i < 4; i++) begin
            write_border(DIRECTED_BORDER[i]);
            send_item(ACT_TICK, 13'($urandom_range(8191)), 8'($urandom_range(255)), 1'(i));
            send_item(ACT_TICK, 13'($urandom_range(8191)), 8'($urandom_range(255)), 1'(~i));
        end

        // write part of the store while the raster is still in the top border
        idle_pct  = 7;
        stall_pct = 7;
        for (int a = 0; a < FILL_WRITES; a++) begin
            if ($urandom_range(3) == 0) begin
                send_item(ACT_TICK, 13'($urandom_range(8191)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
            send_item(ACT_WRITE, 13'(a), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end

        for (int p = 0; p < 4; p++) begin
            write_border(SWEEP_BORDER[p]);
            idle_pct  = (p == 1) ? 54 : (p == 3) ? 7 : 0;
            stall_pct = (p == 2) ? 54 : (p == 3) ? 7 : 0;
            if (p == 0) begin
                hold_requests++;
            end
            for (int n = 0; n < SWEEP_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 90) begin
                    send_item(ACT_TICK, 13'($urandom_range(8191)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                end else begin
                    if (pick < 93) begin
                        addr = 13'($urandom_range(8191, 6912));
                    end else if (pick < 97 && pixels.in_picture()) begin
                        addr = pixels.cell_offset(1'($urandom_range(1)));
                    end else begin
                        addr = 13'($urandom_range(6911));
                    end
                    send_item(ACT_WRITE, addr, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
        end

        drain();
        if (pixels.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
